// File: src/double_lifo_stack_with_search_macros.svh
// Assertion macros for the double LIFO stack with search
`ifndef DOUBLE_LIFO_STACK_WITH_SEARCH_MACROS_SVH
`define DOUBLE_LIFO_STACK_WITH_SEARCH_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define DLS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%s failed", "label");
// next-cycle implication
`define DLS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%s failed", "label");
`endif

// File: src/dls_pkg.sv
// Package: opcodes, status codes, controller types and the IEEE compare
`timescale 1ns / 1ps
package dls_pkg;
  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_TOP    = 3'd2;
  localparam logic [2:0] OP_BOTTOM = 3'd3;
  localparam logic [2:0] OP_SEARCH = 3'd4;
  localparam logic [2:0] OP_DUMP   = 3'd5;
  localparam logic [2:0] OP_CLEAR  = 3'd6;
  localparam logic [2:0] OP_NONE   = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_WALK, S_OUT, S_WAIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       latch_in;   // capture the command beat
    logic       do_push;
    logic       do_pop;
    logic       do_clear;
    logic       rd_top;     // read address: top
    logic       rd_bottom;  // read address: bottom
    logic       rd_walk;    // read address: walk pointer
    logic       walk_start; // load walk pointer
    logic       walk_step;  // advance walk pointer
    logic       load_out;   // load output register
    logic [1:0] out_status;
    logic       out_data;   // output carries read data
    logic       out_count;  // output carries match count
    logic       out_last;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic       empty;
    logic       full;
    logic [2:0] opcode;
    logic       walk_end;  // walk pointer on its final entry
  } sts_t;

  function automatic logic ieee_eq(input logic [63:0] a, input logic [63:0] b);
    logic nan_a, nan_b, zero_ab;
    nan_a   = a[62:0] > 63'h7FF0000000000000;
    nan_b   = b[62:0] > 63'h7FF0000000000000;
    zero_ab = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    return !nan_a && !nan_b && (zero_ab || a == b);
  endfunction
endpackage

// File: src/dls_datapath.sv
// Datapath: entry memory, occupancy, walk pointer, match counter and output register
`timescale 1ns / 1ps
module dls_datapath #(
  parameter int DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [2:0]   in_opcode,
  input  logic [63:0]  in_value,
  input  dls_pkg::ctl_t ctl,
  output dls_pkg::sts_t sts,
  output logic [1:0]   out_status,
  output logic [63:0]  out_data,
  output logic [6:0]   out_count,
  output logic         out_last
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data_r;
  logic [OW-1:0] occ_r, occ_nxt;
  logic [AW-1:0] walk_r, walk_nxt;
  logic [OW-1:0] left_r, left_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        cmp_v_r;  // rd_data_r holds a search entry to compare
  logic [2:0]  op_r;
  logic [63:0] key_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] top_addr;

  assign top_addr = AW'(occ_r - OW'(1));

  always_comb begin
    rd_addr = walk_r;
    if (ctl.rd_top) rd_addr = top_addr;
    else if (ctl.rd_bottom) rd_addr = '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.do_push) mem[occ_r[AW-1:0]] <= key_r;
    if (ctl.rd_top || ctl.rd_bottom || ctl.rd_walk) rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    occ_nxt = occ_r;
    if (ctl.do_push) occ_nxt = occ_r + OW'(1);
    else if (ctl.do_pop) occ_nxt = occ_r - OW'(1);
    else if (ctl.do_clear) occ_nxt = '0;
    walk_nxt = walk_r;
    left_nxt = left_r;
    cnt_nxt  = cnt_r;
    if (ctl.walk_start) begin
      walk_nxt = (op_r == dls_pkg::OP_DUMP) ? top_addr : '0;
      left_nxt = occ_r;
      cnt_nxt  = '0;
    end else begin
      if (ctl.walk_step) begin
        walk_nxt = (op_r == dls_pkg::OP_DUMP) ? walk_r - AW'(1) : walk_r + AW'(1);
        left_nxt = left_r - OW'(1);
      end
      if (cmp_v_r && dls_pkg::ieee_eq(rd_data_r, key_r)) cnt_nxt = cnt_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= '0;
      cmp_v_r <= 1'b0;
    end else begin
      occ_r   <= occ_nxt;
      cmp_v_r <= ctl.walk_step && (op_r == dls_pkg::OP_SEARCH);
    end
    walk_r <= walk_nxt;
    left_r <= left_nxt;
    cnt_r  <= cnt_nxt;
    if (ctl.latch_in) begin
      op_r  <= in_opcode;
      key_r <= in_value;
    end
    if (ctl.load_out) begin
      out_status <= ctl.out_status;
      out_data   <= ctl.out_data ? rd_data_r : 64'd0;
      out_count  <= ctl.out_count ? cnt_r : 7'd0;
      out_last   <= ctl.out_last;
    end
  end

  assign sts.empty    = (occ_r == '0);
  assign sts.full     = (occ_r == OW'(DEPTH));
  assign sts.opcode   = op_r;
  assign sts.walk_end = (left_r == OW'(1));
endmodule

// File: src/dls_controller.sv
// Controller: command sequencing and output handshake
`timescale 1ns / 1ps
module dls_controller (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  dls_pkg::sts_t sts,
  output dls_pkg::ctl_t ctl
);
  dls_pkg::state_t state_r, state_nxt;
  logic vld_r, vld_nxt;
  logic fin_r, fin_nxt;  // current beat closes the command
  logic slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dls_pkg::S_IDLE;
      vld_r   <= 1'b0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      fin_r   <= fin_nxt;
    end
  end

  assign slot_free  = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign in_tready  = (state_r == dls_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    vld_nxt   = vld_r && !out_tready;
    fin_nxt   = fin_r;
    ctl       = '0;
    unique case (state_r)
      dls_pkg::S_IDLE: begin
        ctl.latch_in = 1'b1;
        if (in_tvalid) state_nxt = dls_pkg::S_READ;
      end
      dls_pkg::S_READ: begin
        // decide; memory read of top or bottom issued here
        ctl.rd_top    = (sts.opcode == dls_pkg::OP_POP) || (sts.opcode == dls_pkg::OP_TOP);
        ctl.rd_bottom = (sts.opcode == dls_pkg::OP_BOTTOM);
        if (sts.opcode == dls_pkg::OP_NONE) begin
          state_nxt = dls_pkg::S_IDLE;
        end else if (sts.empty && sts.opcode != dls_pkg::OP_PUSH) begin
          state_nxt = dls_pkg::S_WAIT;
        end else if (sts.opcode == dls_pkg::OP_SEARCH || sts.opcode == dls_pkg::OP_DUMP) begin
          ctl.walk_start = 1'b1;
          state_nxt = dls_pkg::S_WALK;
        end else begin
          state_nxt = dls_pkg::S_WAIT;
        end
      end
      dls_pkg::S_WALK: begin
        ctl.rd_walk = 1'b1;
        if (sts.opcode == dls_pkg::OP_SEARCH) begin
          ctl.walk_step = 1'b1;
          if (sts.walk_end) state_nxt = dls_pkg::S_OUT;
        end else begin
          // read issued; next state emits it
          fin_nxt = sts.walk_end;
          state_nxt = dls_pkg::S_OUT;
        end
      end
      dls_pkg::S_OUT: begin
        if (sts.opcode == dls_pkg::OP_SEARCH) begin
          // last entry compared here
          state_nxt = dls_pkg::S_WAIT;
        end else if (slot_free) begin
          ctl.load_out  = 1'b1;
          ctl.out_data  = 1'b1;
          ctl.out_last  = fin_r;
          ctl.walk_step = 1'b1;
          vld_nxt = 1'b1;
          state_nxt = fin_r ? dls_pkg::S_IDLE : dls_pkg::S_WALK;
        end
      end
      dls_pkg::S_WAIT: begin
        if (slot_free) begin
          ctl.load_out = 1'b1;
          ctl.out_last = 1'b1;
          vld_nxt = 1'b1;
          state_nxt = dls_pkg::S_IDLE;
          if (sts.empty && sts.opcode != dls_pkg::OP_PUSH) begin
            ctl.out_status = dls_pkg::ST_EMPTY;
          end else begin
            unique case (sts.opcode)
              dls_pkg::OP_PUSH: begin
                if (sts.full) ctl.out_status = dls_pkg::ST_FULL;
                else ctl.do_push = 1'b1;
              end
              dls_pkg::OP_POP: begin
                ctl.out_data = 1'b1;
                ctl.do_pop   = 1'b1;
              end
              dls_pkg::OP_TOP, dls_pkg::OP_BOTTOM: ctl.out_data = 1'b1;
              dls_pkg::OP_SEARCH: ctl.out_count = 1'b1;
              dls_pkg::OP_CLEAR: ctl.do_clear = 1'b1;
              default: ;
            endcase
          end
        end
      end
      default: state_nxt = dls_pkg::S_IDLE;
    endcase
  end
endmodule

// File: src/double_lifo_stack_with_search.sv
// Top level: LIFO stack of doubles with top, bottom, search and dump
// Push/pop/top/bottom/clear: the beat is latched in S_IDLE, decided in S_READ, answered from S_WAIT.
// Search: S_WALK steps over every entry, S_OUT compares the last and S_WAIT emits the count; dump:
// S_WALK reads and S_OUT emits each entry in turn (single registered read port); output stalls hold S_OUT/S_WAIT.
// in_tready is high only while the controller is idle; synchronous active-low reset
// empties the stack and drops any pending beat; entry memory is not cleared.
`timescale 1ns / 1ps
`include "double_lifo_stack_with_search_macros.svh"
module double_lifo_stack_with_search #(
  parameter int DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // value[63:0]
  input  logic [2:0]   in_tuser,   // opcode[2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata,  // status[1:0], data[65:2], match_count[72:66], pad
  output logic         out_tlast
);
  dls_pkg::ctl_t ctl;
  dls_pkg::sts_t sts;
  logic [1:0]  st;
  logic [63:0] dat;
  logic [6:0]  cnt;

  dls_controller u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .sts, .ctl
  );

  dls_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk, .rst_n, .in_opcode(in_tuser), .in_value(in_tdata), .ctl, .sts,
    .out_status(st), .out_data(dat), .out_count(cnt), .out_last(out_tlast)
  );

  assign out_tdata = {7'd0, cnt, dat, st};

  `DLS_ASSERT_IMP(a_busy_no_ready, out_tvalid && !out_tready && !in_tready, !ctl.load_out)
  `DLS_ASSERT_NXT(a_push_full, ctl.do_push, !(sts.full && ctl.do_push))
  `DLS_ASSERT_IMP(a_one_write, ctl.do_push, !ctl.do_pop && !ctl.do_clear)
endmodule

// File: bench/double_lifo_stack_with_search_tb.sv
// Testbench for the double LIFO stack: directed and random commands checked against a predictor
`timescale 1ns / 1ps
module double_lifo_stack_with_search_tb;
  localparam int DEPTH = 64;

  typedef struct {
    logic [2:0]  op;
    logic [63:0] value;
  } cmd_t;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] data;
    logic [6:0]  count;
    logic        last;
  } res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [79:0]  out_tdata;
  logic         out_tlast;

  cmd_t        cmd_q[$];
  res_t        result_q[$];
  logic [63:0] stack_mem[DEPTH];
  int          depth_used = 0;
  int          errs = 0;
  int          beats_in = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  logic [63:0] pool[8];

  double_lifo_stack_with_search #(.DEPTH(DEPTH)) dut (.*);

  always #6 clk = ~clk;

  function automatic bit is_nan(logic [63:0] v);
    return v[62:0] > 63'h7FF0000000000000;
  endfunction

  function automatic bit dbl_equal(logic [63:0] a, logic [63:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (a[62:0] == '0 && b[62:0] == '0) return 1'b1;
    return a == b;
  endfunction

  function automatic res_t mk(logic [1:0] st, logic [63:0] d, logic [6:0] c, logic l);
    res_t r;
    r.status = st;
    r.data = d;
    r.count = c;
    r.last = l;
    return r;
  endfunction

  task automatic predict_stack(logic [2:0] op, logic [63:0] v);
    int c;
    c = 0;
    if (op == dls_pkg::OP_NONE) return;
    if (op == dls_pkg::OP_PUSH) begin
      if (depth_used >= DEPTH) result_q.push_back(mk(dls_pkg::ST_FULL, '0, '0, 1'b1));
      else begin
        stack_mem[depth_used] = v;
        depth_used++;
        result_q.push_back(mk(dls_pkg::ST_OK, '0, '0, 1'b1));
      end
      return;
    end
    if (depth_used == 0) begin
      result_q.push_back(mk(dls_pkg::ST_EMPTY, '0, '0, 1'b1));
      return;
    end
    case (op)
      dls_pkg::OP_POP: begin
        result_q.push_back(mk(dls_pkg::ST_OK, stack_mem[depth_used-1], '0, 1'b1));
        depth_used--;
      end
      dls_pkg::OP_TOP:
        result_q.push_back(mk(dls_pkg::ST_OK, stack_mem[depth_used-1], '0, 1'b1));
      dls_pkg::OP_BOTTOM: result_q.push_back(mk(dls_pkg::ST_OK, stack_mem[0], '0, 1'b1));
      dls_pkg::OP_SEARCH: begin
        for (int i = 0; i < depth_used; i++) if (dbl_equal(stack_mem[i], v)) c++;
        result_q.push_back(mk(dls_pkg::ST_OK, '0, 7'(c), 1'b1));
      end
      dls_pkg::OP_DUMP:
        for (int i = 0; i < depth_used; i++)
          result_q.push_back(mk(dls_pkg::ST_OK, stack_mem[depth_used-1-i], '0,
                                i == depth_used - 1));
      default: begin
        depth_used = 0;
        result_q.push_back(mk(dls_pkg::ST_OK, '0, '0, 1'b1));
      end
    endcase
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    errs++;
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(9))
      0: return 64'h0000000000000000;
      1: return 64'h8000000000000000;
      2: return {1'($urandom_range(1)), 11'h7FF, 52'h0};
      3: return {1'($urandom_range(1)), 11'h7FF, 20'($urandom), 32'($urandom) | 32'd1};
      4, 5, 6: return pool[3'($urandom_range(7))];
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add(logic [2:0] op, logic [63:0] v);
    cmd_t c;
    c.op = op;
    c.value = v;
    cmd_q.push_back(c);
  endtask

  // driver; prediction taken on each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_stack(in_tuser, in_tdata);
        beats_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (cmd_q.size() > 0 && ((beats_in > 120 && beats_in < 180) ||
                                 $urandom_range(99) >= 34)) begin
          cmd_t c;
          c = cmd_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= c.op;
          in_tdata <= c.value;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          report("unexpected beat", out_tdata[65:2], '0);
        end else begin
          res_t e;
          e = result_q.pop_front();
          if (out_tdata[1:0] !== e.status)
            report("status", 64'(out_tdata[1:0]), 64'(e.status));
          if (out_tdata[65:2] !== e.data) report("data", out_tdata[65:2], e.data);
          if (out_tdata[72:66] !== e.count)
            report("match_count", 64'(out_tdata[72:66]), 64'(e.count));
          if (out_tlast !== e.last) report("last", 64'(out_tlast), 64'(e.last));
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (!hold_done && beats_in >= 200) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_tready <= 1'b0;
      end else begin
        out_tready <= (beats_in > 60 && beats_in < 110) || $urandom_range(99) >= 34;
      end
    end
  end

  initial begin
    int n;
    int r;
    n = 0;
    foreach (pool[i]) pool[i] = {$urandom, $urandom};
    add(dls_pkg::OP_POP, '0); add(dls_pkg::OP_TOP, '0); add(dls_pkg::OP_BOTTOM, '0);
    add(dls_pkg::OP_SEARCH, '0); add(dls_pkg::OP_DUMP, '0); add(dls_pkg::OP_CLEAR, '0);
    add(dls_pkg::OP_PUSH, 64'h0); add(dls_pkg::OP_TOP, '0);
    add(dls_pkg::OP_PUSH, 64'h8000000000000000); add(dls_pkg::OP_SEARCH, 64'h0);
    add(dls_pkg::OP_PUSH, 64'h7FF8000000000000);
    add(dls_pkg::OP_SEARCH, 64'h7FF8000000000000);
    add(dls_pkg::OP_PUSH, 64'hFFFFFFFFFFFFFFFF);
    add(dls_pkg::OP_PUSH, 64'h7FF0000000000000);
    add(dls_pkg::OP_SEARCH, 64'hFFF0000000000000);
    add(dls_pkg::OP_SEARCH, 64'h7FF0000000000000);
    add(dls_pkg::OP_NONE, 64'h1234); add(dls_pkg::OP_DUMP, '0);
    add(dls_pkg::OP_BOTTOM, '0);
    add(dls_pkg::OP_POP, '0); add(dls_pkg::OP_POP, '0); add(dls_pkg::OP_CLEAR, '0);
    add(dls_pkg::OP_TOP, '0);
    n = 23;
    while (n < 260) begin
      r = $urandom_range(9);
      if (r < 4) begin
        repeat ($urandom_range(1, 8)) begin add(dls_pkg::OP_PUSH, pick_value()); n++; end
      end else if (r == 4 && $urandom_range(3) == 0) begin
        repeat (DEPTH + 2) begin add(dls_pkg::OP_PUSH, pick_value()); n++; end
        add(dls_pkg::OP_SEARCH, pool[3'($urandom_range(7))]);
        add(dls_pkg::OP_DUMP, '0);
        add(dls_pkg::OP_POP, '0);
        n += 3;
      end else begin
        add(3'($urandom_range(7)), pick_value());
        n++;
      end
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (cmd_q.size() == 0);
    @(posedge clk);
    while (in_tvalid || result_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errs == 0 && result_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
